// File: sv/bwt_pkg.sv
// package: shared constants and controller/datapath command and status types
`default_nettype none
package bwt_pkg;

  localparam int unsigned BLOCK_SIZE_DEF = 64;

  typedef struct packed {
    logic load;
    logic sent;
    logic place;
    logic rd_prev;
    logic cstart;
    logic crd;
    logic cadv;
    logic shift;
    logic erd;
    logic etx;
    logic oload;
    logic knext;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic j_zero;
    logic last_i;
    logic diff;
    logic less;
    logic cmp_end;
    logic last_k;
    logic taken;
  } status_t;

endpackage
`default_nettype wire

// File: sv/bwt_ctrl.sv
// controller: state machine sequencing load, rotation sort and emission
`default_nettype none
module bwt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            block_end_i,
  input  wire bwt_pkg::status_t st_i,
  output bwt_pkg::cmd_t        cmd_o,
  output logic                 in_stall_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SENT  = 4'd1;
  localparam logic [3:0] S_JCHK  = 4'd2;
  localparam logic [3:0] S_CST   = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CEV   = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_PLACE = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_ETX   = 4'd9;
  localparam logic [3:0] S_EOUT  = 4'd10;
  localparam logic [3:0] S_EWAIT = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (block_end_i) state_d = S_SENT;
        end
      end
      S_SENT: begin
        cmd_o.sent = 1'b1;
        state_d    = S_JCHK;
      end
      S_JCHK: begin
        if (st_i.j_zero) begin
          cmd_o.place = 1'b1;
          state_d     = st_i.last_i ? S_ERD : S_JCHK;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_CST;
        end
      end
      S_CST: begin
        cmd_o.cstart = 1'b1;
        state_d      = S_CRD;
      end
      S_CRD: begin
        cmd_o.crd = 1'b1;
        state_d   = S_CEV;
      end
      S_CEV: begin
        if (st_i.diff) begin
          state_d = st_i.less ? S_SHIFT : S_PLACE;
        end else if (st_i.cmp_end) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.cadv = 1'b1;
          state_d    = S_CRD;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = S_JCHK;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = st_i.last_i ? S_ERD : S_JCHK;
      end
      S_ERD: begin
        cmd_o.erd = 1'b1;
        state_d   = S_ETX;
      end
      S_ETX: begin
        cmd_o.etx = 1'b1;
        state_d   = S_EOUT;
      end
      S_EOUT: begin
        cmd_o.oload = 1'b1;
        state_d     = S_EWAIT;
      end
      S_EWAIT: begin
        if (st_i.taken) begin
          if (st_i.last_k) begin
            cmd_o.done = 1'b1;
            state_d    = S_IDLE;
          end else begin
            cmd_o.knext = 1'b1;
            state_d     = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/bwt_dp.sv
// datapath: text and order memories, sort counters, compare and output word
`default_nettype none
module bwt_dp #(
  parameter int unsigned BLOCK_SIZE = bwt_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bwt_pkg::cmd_t   cmd_i,
  output bwt_pkg::status_t     st_o,
  input  wire logic [7:0]      data_byte_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 overflowed_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i
);

  localparam int unsigned AW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam logic [AW-1:0] LEN_MAX = AW'(BLOCK_SIZE - 1);

  logic [7:0]    text_mem [BLOCK_SIZE];
  logic [AW-1:0] ord_mem  [BLOCK_SIZE];

  logic [AW-1:0] len_q, i_q, j_q, k_q, pa_q, pb_q, kc_q, ord_rd_q;
  logic          ovf_q, out_valid_q, out_last_q, out_ovf_q;
  logic [7:0]    ta_q, tb_q, out_byte_q;

  logic          room;
  logic          txt_we, ord_we, txt_re, ord_re;
  logic [AW-1:0] txt_wa, txt_ra, ord_ra, ord_wd, endpos;
  logic [7:0]    txt_wd;

  assign room   = (len_q != LEN_MAX);
  assign endpos = (ord_rd_q == '0) ? len_q : ord_rd_q - 1'b1;

  assign txt_we = (cmd_i.load && room) || cmd_i.sent;
  assign txt_wa = len_q;
  assign txt_wd = cmd_i.sent ? 8'd0 : data_byte_i;
  assign txt_re = cmd_i.crd || cmd_i.etx;
  assign txt_ra = cmd_i.etx ? endpos : pa_q;

  assign ord_we = cmd_i.shift || cmd_i.place;
  assign ord_wd = cmd_i.shift ? ord_rd_q : i_q;
  assign ord_re = cmd_i.rd_prev || cmd_i.erd;
  assign ord_ra = cmd_i.rd_prev ? j_q - 1'b1 : k_q;

  always_ff @(posedge clk_i) begin
    if (txt_we) text_mem[txt_wa] <= txt_wd;
    if (txt_re) begin
      ta_q <= text_mem[txt_ra];
      tb_q <= text_mem[pb_q];
    end
    if (ord_we) ord_mem[j_q] <= ord_wd;
    if (ord_re) ord_rd_q <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      kc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (room) len_q <= len_q + 1'b1;
        else      ovf_q <= 1'b1;
      end
      if (cmd_i.sent) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
      if (cmd_i.place && (i_q != len_q)) begin
        i_q <= i_q + 1'b1;
        j_q <= i_q + 1'b1;
      end
      if (cmd_i.shift) j_q <= j_q - 1'b1;
      if (cmd_i.cstart) begin
        pa_q <= i_q;
        pb_q <= ord_rd_q;
        kc_q <= '0;
      end
      if (cmd_i.cadv) begin
        pa_q <= (pa_q == len_q) ? '0 : pa_q + 1'b1;
        pb_q <= (pb_q == len_q) ? '0 : pb_q + 1'b1;
        kc_q <= kc_q + 1'b1;
      end
      if (cmd_i.oload) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.knext) k_q <= k_q + 1'b1;
      if (cmd_i.done) begin
        len_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.oload) begin
      out_byte_q <= ta_q;
      out_last_q <= (k_q == len_q);
      out_ovf_q  <= ovf_q;
    end
  end

  assign st_o.j_zero  = (j_q == '0);
  assign st_o.last_i  = (i_q == len_q);
  assign st_o.diff    = (ta_q != tb_q);
  assign st_o.less    = (ta_q < tb_q);
  assign st_o.cmp_end = (kc_q == len_q);
  assign st_o.last_k  = (k_q == len_q);
  assign st_o.taken   = out_valid_q && !out_stall_i;

  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign overflowed_o = out_ovf_q;
  assign out_valid_o  = out_valid_q;

endmodule
`default_nettype wire

// File: sv/bwt_block_encoder_core.sv
// top level: burrows-wheeler block encoder, controller plus datapath
//
// channel | direction | payload                            | handshake
// input   | in        | data_byte_i, block_end_i           | in_valid_i / in_stall_o
// output  | out       | out_byte_o, out_last_o, overflowed_o | out_valid_o / out_stall_i
//
// text bytes load while the core is idle; the closing byte starts an insertion sort
// of the n = length + 1 rotations, each byte compared in a read state and an
// evaluate state, so the worst case is set by the single text memory compare loop
// each result then passes through the ERD, ETX, EOUT and EWAIT states, the last held by any output stall
// reset clears control state only; memories are written before being read
// input stalls from the closing byte until the last result is taken
`default_nettype none
module bwt_block_encoder_core #(
  parameter int unsigned BLOCK_SIZE = bwt_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       block_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            overflowed_o
);

  bwt_pkg::cmd_t    cmd;
  bwt_pkg::status_t st;

  bwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .block_end_i (block_end_i),
    .st_i        (st),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  bwt_dp #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .data_byte_i  (data_byte_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .overflowed_o (overflowed_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule
`default_nettype wire
